/* src/rpg_pkg.sv */
package rpg_pkg;

   localparam int COORD_W    = 12;
   localparam int SZ_W       = 13;
   localparam int CH_W       = 8;
   localparam int ADDR_W     = 24;
   localparam int QUOT_W     = 8;
   localparam int SEC_W      = 2;
   localparam int NUM_CH     = 3;
   localparam int NUM_LANES  = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int MAX_SIZE_DEF = 4096;
   localparam logic [SZ_W-1:0] SIZE_RESET = 13'd256;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_PITCH    = 2'd2;

   localparam int LANE_ROW = 0;
   localparam int LANE_COL = 1;

   typedef struct packed {
      logic [SZ_W-1:0] width;
      logic [SZ_W-1:0] height;
      logic [SZ_W-1:0] pitch;
   } cfg_type;

   // per-item data that rides along with the divider lanes
   typedef struct packed {
      logic                outside;
      logic [SEC_W-1:0]    sec;
      logic [ADDR_W-1:0]   prod;
      logic [COORD_W-1:0]  col;
   } side_type;

   typedef struct packed {
      logic                oor;
      logic [ADDR_W-1:0]   addr;
      logic [CH_W-1:0]     blue;
      logic [CH_W-1:0]     green;
      logic [CH_W-1:0]     red;
   } rsp_type;

   // anchor colors: red, yellow, cyan, magenta; channel 0 red, 1 green, 2 blue
   function automatic logic [CH_W-1:0] anchor_chan(input logic [SEC_W-1:0] sec,
                                                   input logic [1:0] ch);
      logic [3:0] mask;
      case (sec)
         2'd0:    mask = 4'b0001;
         2'd1:    mask = 4'b0011;
         2'd2:    mask = 4'b0110;
         default: mask = 4'b0101;
      endcase
      return mask[ch] ? {CH_W{1'b1}} : {CH_W{1'b0}};
   endfunction

endpackage

/* src/rpg_front.sv */
module rpg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  rpg_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   input  logic [rpg_pkg::COORD_W-1:0]   col,
   input  logic [rpg_pkg::COORD_W-1:0]   row,
   output logic                          out_valid,
   output logic [rpg_pkg::NUM_LANES-1:0][rpg_pkg::SZ_W-1:0] num,
   output logic [rpg_pkg::NUM_LANES-1:0][rpg_pkg::SZ_W-1:0] den,
   output rpg_pkg::side_type             side
);
   import rpg_pkg::*;

   logic [SZ_W-1:0]   col_x, row_x;
   logic [SZ_W-1:0]   b1, b2, b3, start, next;
   logic [SZ_W+1:0]   three_h;
   logic [SEC_W-1:0]  sec;
   logic              valid_ff;
   logic [NUM_LANES-1:0][SZ_W-1:0] num_ff, den_ff, num_in, den_in;
   side_type          side_ff, side_in;

   always_comb begin
      col_x   = {1'b0, col};
      row_x   = {1'b0, row};
      b1      = {2'b00, cfg.height[SZ_W-1:2]};
      b2      = {1'b0, cfg.height[SZ_W-1:1]};
      three_h = {2'b00, cfg.height} + {1'b0, cfg.height, 1'b0};
      b3      = three_h[SZ_W+1:2];
      // highest section whose start is at or below the row
      if (row_x >= b3) begin
         sec = 2'd3; start = b3; next = cfg.height;
      end else if (row_x >= b2) begin
         sec = 2'd2; start = b2; next = b3;
      end else if (row_x >= b1) begin
         sec = 2'd1; start = b1; next = b2;
      end else begin
         sec = 2'd0; start = '0; next = b1;
      end
      num_in[LANE_ROW] = row_x - start;
      den_in[LANE_ROW] = next - start;
      num_in[LANE_COL] = col_x;
      den_in[LANE_COL] = cfg.width;
      side_in.outside  = (col_x >= cfg.width) || (row_x >= cfg.height);
      side_in.sec      = sec;
      side_in.prod     = {{(ADDR_W-COORD_W){1'b0}}, row} *
                         {{(ADDR_W-SZ_W){1'b0}}, cfg.pitch};
      side_in.col      = col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ce) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign num       = num_ff;
   assign den       = den_ff;
   assign side      = side_ff;

endmodule

/* src/rpg_div_pipe.sv */
module rpg_div_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  logic [rpg_pkg::NUM_LANES-1:0][rpg_pkg::SZ_W-1:0] num,
   input  logic [rpg_pkg::NUM_LANES-1:0][rpg_pkg::SZ_W-1:0] den,
   input  rpg_pkg::side_type             side_i,
   output logic                          out_valid,
   output logic [rpg_pkg::NUM_LANES-1:0][rpg_pkg::QUOT_W-1:0] quo,
   output rpg_pkg::side_type             side_o
);
   import rpg_pkg::*;

   localparam int NS = QUOT_W;

   // one quotient bit per stage; numerator is num*2^QUOT_W with num < den
   logic [NS-1:0][NUM_LANES-1:0][SZ_W-1:0]   rem_ff, rem_in, den_ff, den_in;
   logic [NS-1:0][NUM_LANES-1:0][QUOT_W-1:0] quo_ff, quo_in;
   logic [NS-1:0]                            valid_ff, valid_in;
   side_type                                 side_ff [NS];
   side_type                                 side_in [NS];

   always_comb begin
      logic [SZ_W:0]   trial;
      logic [SZ_W-1:0] rem_prev, den_prev;
      logic [QUOT_W-1:0] quo_prev;
      for (int s = 0; s < NS; s++) begin
         valid_in[s] = (s == 0) ? in_valid : valid_ff[s-1];
         side_in[s]  = (s == 0) ? side_i   : side_ff[s-1];
         for (int l = 0; l < NUM_LANES; l++) begin
            rem_prev = (s == 0) ? num[l] : rem_ff[s-1][l];
            den_prev = (s == 0) ? den[l] : den_ff[s-1][l];
            quo_prev = (s == 0) ? '0     : quo_ff[s-1][l];
            trial = {rem_prev, 1'b0};
            den_in[s][l] = den_prev;
            if (trial >= {1'b0, den_prev}) begin
               rem_in[s][l] = SZ_W'(trial - {1'b0, den_prev});
               quo_in[s][l] = {quo_prev[QUOT_W-2:0], 1'b1};
            end else begin
               rem_in[s][l] = trial[SZ_W-1:0];
               quo_in[s][l] = {quo_prev[QUOT_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff  <= rem_in;
         den_ff  <= den_in;
         quo_ff  <= quo_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign quo       = quo_ff[NS-1];
   assign side_o    = side_ff[NS-1];

endmodule

/* src/rpg_shade.sv */
module rpg_shade (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  logic [rpg_pkg::NUM_LANES-1:0][rpg_pkg::QUOT_W-1:0] quo,
   input  rpg_pkg::side_type             side,
   output logic                          out_valid,
   output rpg_pkg::rsp_type              rsp
);
   import rpg_pkg::*;

   logic [CH_W-1:0]   wt, lum, wt2_in;
   logic [CH_W-2:0]   lum_off;
   logic [2*CH_W-1:0] mix_a, mix_b;
   logic [NUM_CH-1:0][CH_W-1:0] row_in;
   logic [NUM_CH-1:0][CH_W-1:0] shade_in;
   logic [CH_W-1:0]   tone;

   logic              valid_a_ff, valid_b_ff;
   logic [NUM_CH-1:0][CH_W-1:0] row_a_ff;
   logic [CH_W-1:0]   wt2_a_ff;
   logic              dark_a_ff, oor_a_ff;
   logic [ADDR_W-1:0] addr_a_ff, addr_in;
   rsp_type           rsp_b_ff, rsp_in;

   // stage a: hue blend between adjacent anchors, brightness weight
   always_comb begin
      wt  = quo[LANE_ROW];
      lum = quo[LANE_COL];
      for (int c = 0; c < NUM_CH; c++) begin
         mix_a = {{CH_W{1'b0}}, anchor_chan(side.sec, 2'(c))} * {{CH_W{1'b0}}, ~wt} +
                 {{CH_W{1'b0}}, anchor_chan(side.sec + 2'd1, 2'(c))} *
                 {{CH_W{1'b0}}, wt};
         row_in[c] = mix_a[2*CH_W-1:CH_W];
      end
      // v*255/127 is 2v, plus one at v = 127
      lum_off = lum[CH_W-1] ? lum[CH_W-2:0] : ~lum[CH_W-2:0];
      wt2_in  = {lum_off, 1'b0} + {{(CH_W-1){1'b0}}, &lum_off};
      addr_in = side.prod + {{(ADDR_W-COORD_W){1'b0}}, side.col};
   end

   // stage b: blend toward black or white; out-of-range items give black
   always_comb begin
      tone = dark_a_ff ? {CH_W{1'b0}} : {CH_W{1'b1}};
      for (int c = 0; c < NUM_CH; c++) begin
         mix_b = {{CH_W{1'b0}}, row_a_ff[c]} * {{CH_W{1'b0}}, ~wt2_a_ff} +
                 {{CH_W{1'b0}}, tone} * {{CH_W{1'b0}}, wt2_a_ff};
         shade_in[c] = oor_a_ff ? {CH_W{1'b0}} : mix_b[2*CH_W-1:CH_W];
      end
      rsp_in.red   = shade_in[0];
      rsp_in.green = shade_in[1];
      rsp_in.blue  = shade_in[2];
      rsp_in.addr  = addr_a_ff;
      rsp_in.oor   = oor_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (ce) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         row_a_ff  <= row_in;
         wt2_a_ff  <= wt2_in;
         dark_a_ff <= ~lum[CH_W-1];
         oor_a_ff  <= side.outside;
         addr_a_ff <= addr_in;
         rsp_b_ff  <= rsp_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign rsp       = rsp_b_ff;

endmodule

/* src/rpg_out_skid.sv */
module rpg_out_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  rpg_pkg::rsp_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output rpg_pkg::rsp_type out_data,
   input  logic             out_ready
);
   import rpg_pkg::*;

   logic    main_vld_ff, skid_vld_ff;
   rsp_type main_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_ready) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (in_valid) begin
         if (main_vld_ff && !out_ready) begin
            skid_vld_ff <= 1'b1;
         end else begin
            main_vld_ff <= 1'b1;
         end
      end else if (out_ready) begin
         main_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_ready) begin
            main_ff <= skid_ff;
         end
      end else if (in_valid) begin
         if (main_vld_ff && !out_ready) begin
            skid_ff <= in_data;
         end else begin
            main_ff <= in_data;
         end
      end
   end

   // pipeline holds while the spare slot is occupied
   assign in_ready  = ~skid_vld_ff;
   assign out_valid = main_vld_ff;
   assign out_data  = main_ff;

endmodule

/* src/rainbow_palette_pixel_generator_top.sv */
// path: a req item passes the front, divider, shade a, shade b and skid main registers
// rate: one item per clock unless held; 12 register stages, 8 a one-bit-per-stage divider
// stall: an output skid slot absorbs one item, then the whole pipeline holds
// reset: synchronous, clears all valid bits and loads 256 into the three size registers
module rainbow_palette_pixel_generator_top #(
   parameter int MAX_SIZE = rpg_pkg::MAX_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,  // column, row
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [47:0]                     rsp_tdata,  // red, green, blue, pixel_address
   output logic                            rsp_tuser,  // out_of_range
   input  logic                            csr_we,
   input  logic [rpg_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [rpg_pkg::SZ_W-1:0]        csr_wdata
);
   import rpg_pkg::*;

   cfg_type         cfg_ff;
   logic [SZ_W-1:0] size_in;
   logic            ce;

   logic            fr_valid, dv_valid, sh_valid;
   logic [NUM_LANES-1:0][SZ_W-1:0]   fr_num, fr_den;
   logic [NUM_LANES-1:0][QUOT_W-1:0] dv_quo;
   side_type        fr_side, dv_side;
   rsp_type         sh_rsp, out_rsp;

   assign size_in = (32'(csr_wdata) > MAX_SIZE) ? SZ_W'(MAX_SIZE) : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= SIZE_RESET;
         cfg_ff.height <= SIZE_RESET;
         cfg_ff.pitch  <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH:  cfg_ff.width  <= size_in;
            CSR_FRAME_HEIGHT: cfg_ff.height <= size_in;
            CSR_ROW_PITCH:    cfg_ff.pitch  <= size_in;
            default: ;
         endcase
      end
   end

   assign req_tready = ce;

   rpg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .col       (req_tdata[11:0]),
      .row       (req_tdata[23:12]),
      .out_valid (fr_valid),
      .num       (fr_num),
      .den       (fr_den),
      .side      (fr_side)
   );

   rpg_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (fr_valid),
      .num       (fr_num),
      .den       (fr_den),
      .side_i    (fr_side),
      .out_valid (dv_valid),
      .quo       (dv_quo),
      .side_o    (dv_side)
   );

   rpg_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (dv_valid),
      .quo       (dv_quo),
      .side      (dv_side),
      .out_valid (sh_valid),
      .rsp       (sh_rsp)
   );

   rpg_out_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sh_valid & ce),
      .in_data   (sh_rsp),
      .in_ready  (ce),
      .out_valid (rsp_tvalid),
      .out_data  (out_rsp),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {out_rsp.addr, out_rsp.blue, out_rsp.green, out_rsp.red};
   assign rsp_tuser = out_rsp.oor;

endmodule
